[rtl/b64c_pkg.sv]
// Shared types, character codes and alphabet functions of the Base64 codec.
// No dependencies; used by b64c_group, b64c_serial and base64_codec.
`default_nettype none

package b64c_pkg;

    localparam logic       MODE_ENC = 1'b0;
    localparam logic       MODE_DEC = 1'b1;
    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // One finished group: up to four result bytes, packed from index 0.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            msg_last;
        logic            bad;
    } burst_t;

    typedef struct packed {
        logic       pad;
        logic       bad;
        logic [5:0] val;
    } sextet_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = 8'h41 + w;
        end else if (v < 6'd52) begin
            c = 8'h61 + w - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + w - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic sextet_t dec_char(input logic [7:0] ch);
        sextet_t    s;
        logic [7:0] d;
        s = '0;
        d = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = ch - 8'h41;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = ch - 8'h61 + 8'd26;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30 + 8'd52;
        end else if (ch == 8'h2B) begin
            d = 8'd62;
        end else if (ch == 8'h2F) begin
            d = 8'd63;
        end else if (ch == PAD_CHAR) begin
            s.pad = 1'b1;
        end else begin
            s.bad = 1'b1;
        end
        s.val = d[5:0];
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/b64c_group.sv]
// Group gatherer: holds the mode register and the partial group, and builds
// the finished result burst. Depends on b64c_pkg.
`default_nettype none

module b64c_group
    import b64c_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       burst_free,
    output logic            burst_load,
    output burst_t          burst
);

    logic        mode_reg;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  count_reg;
    logic [1:0]  pad_reg, pad_next;
    logic        bad_reg, bad_next;
    logic        complete;
    logic        accept;
    sextet_t     sx;
    logic [7:0]  b0, b1, b2;

    assign sx       = dec_char(in_byte);
    assign complete = in_last || ((mode_reg == MODE_DEC) ? (count_reg == 2'd3)
                                                         : (count_reg == 2'd2));
    // An item that only joins the group needs no room in the serializer.
    assign in_ready   = !complete || burst_free;
    assign accept     = in_valid && in_ready;
    assign burst_load = accept && complete;

    always_comb
    begin
        bits_next = bits_reg;
        pad_next  = pad_reg;
        bad_next  = bad_reg;
        if (mode_reg == MODE_ENC) begin
            unique case (count_reg)
                2'd0:    bits_next[23:16] = bits_reg[23:16] | in_byte;
                2'd1:    bits_next[15:8]  = bits_reg[15:8]  | in_byte;
                default: bits_next[7:0]   = bits_reg[7:0]   | in_byte;
            endcase
        end else begin
            unique case (count_reg)
                2'd0:    bits_next[23:18] = bits_reg[23:18] | sx.val;
                2'd1:    bits_next[17:12] = bits_reg[17:12] | sx.val;
                2'd2:    bits_next[11:6]  = bits_reg[11:6]  | sx.val;
                default: bits_next[5:0]   = bits_reg[5:0]   | sx.val;
            endcase
            // A pad in the first two slots is an error and suppresses nothing.
            if (sx.pad && count_reg == 2'd2) pad_next[0] = 1'b1;
            if (sx.pad && count_reg == 2'd3) pad_next[1] = 1'b1;
            if (sx.bad || (sx.pad && !count_reg[1])) bad_next = 1'b1;
        end
    end

    assign b0 = bits_next[23:16];
    assign b1 = bits_next[15:8];
    assign b2 = bits_next[7:0];

    always_comb
    begin
        burst = '0;
        burst.msg_last = in_last;
        if (mode_reg == MODE_ENC) begin
            burst.bytes[0] = enc_char(bits_next[23:18]);
            burst.bytes[1] = enc_char(bits_next[17:12]);
            burst.bytes[2] = (count_reg != 2'd0) ? enc_char(bits_next[11:6]) : PAD_CHAR;
            burst.bytes[3] = (count_reg[1])      ? enc_char(bits_next[5:0])  : PAD_CHAR;
            burst.count    = 3'd4;
        end else begin
            burst.bad      = bad_next;
            burst.bytes[0] = b0;
            burst.bytes[1] = pad_next[0] ? b2 : b1;
            burst.bytes[2] = b2;
            burst.count    = 3'd1 + {2'b00, !pad_next[0]} + {2'b00, !pad_next[1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_ENC;
            bits_reg  <= '0;
            count_reg <= '0;
            pad_reg   <= '0;
            bad_reg   <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg  <= cfg_data;
            bits_reg  <= '0;
            count_reg <= '0;
            pad_reg   <= '0;
            bad_reg   <= 1'b0;
        end else if (accept) begin
            if (complete) begin
                bits_reg  <= '0;
                count_reg <= '0;
                pad_reg   <= '0;
                bad_reg   <= 1'b0;
            end else begin
                bits_reg  <= bits_next;
                count_reg <= count_reg + 2'd1;
                pad_reg   <= pad_next;
                bad_reg   <= bad_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/b64c_serial.sv]
// Output serializer: holds one finished burst and sends it one byte a beat.
// Depends on b64c_pkg.
`default_nettype none

module b64c_serial
    import b64c_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       burst_load,
    input  wire burst_t     burst,
    output logic            burst_free,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            msg_last,
    output logic            bad_char
);

    logic [3:0][7:0] bytes_reg;
    logic [2:0]      rem_reg;
    logic            msg_reg;
    logic            bad_reg;
    logic            take;

    assign out_valid  = (rem_reg != 3'd0);
    assign take       = out_valid && out_ready;
    // Room for a new burst once the last byte of this one leaves.
    assign burst_free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && out_ready);

    assign out_byte = bytes_reg[0];
    assign run_last = (rem_reg == 3'd1);
    assign msg_last = (rem_reg == 3'd1) && msg_reg;
    assign bad_char = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rem_reg <= '0;
        end else if (burst_load) begin
            rem_reg <= burst.count;
        end else if (take) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load) begin
            bytes_reg <= burst.bytes;
            msg_reg   <= burst.msg_last;
            bad_reg   <= burst.bad;
        end else if (take) begin
            bytes_reg <= {8'h00, bytes_reg[3:1]};
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load |-> burst_free)
        else $error("burst loaded while serializer still busy");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load |-> (burst.count != 3'd0 && burst.count <= 3'd4))
        else $error("burst byte count out of range");

    a_load_takes: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load |=> (rem_reg == $past(burst.count)))
        else $error("serializer did not take the loaded burst");

endmodule

`default_nettype wire

[rtl/base64_codec.sv]
// Top level of the streaming Base64 codec: group gatherer and serializer.
// Depends on b64c_pkg, b64c_group and b64c_serial.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_valid/cfg_ready  cfg_data (mode: 0 encode, 1 decode)
//   in       in         in_valid/in_ready    in_byte, in_last
//   out      out        out_valid/out_ready  out_byte, run_last, msg_last, bad_char
//
// A finished group appears at the output the next cycle and leaves one byte a
// beat. Encoding, the four characters of a group hold back the three input bytes;
// decoding takes one character a cycle while out_ready is high.
// An item that finishes a group waits until the previous group's last byte leaves;
// items that only join a group are taken even while the serializer is busy.
// Reset clears the mode to encode and empties the group and the serializer.
// A mode write clears the partial group.
`default_nettype none

module base64_codec
    import b64c_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            msg_last,
    output logic            bad_char
);

    burst_t burst;
    logic   burst_load;
    logic   burst_free;

    assign cfg_ready = 1'b1;

    b64c_group u_group (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .burst_free (burst_free),
        .burst_load (burst_load),
        .burst      (burst)
    );

    b64c_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst_load (burst_load),
        .burst      (burst),
        .burst_free (burst_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .msg_last   (msg_last),
        .bad_char   (bad_char)
    );

endmodule

`default_nettype wire
